FILE: sv/fasd_pkg.sv
// Package: shared constants, types and layout functions for the flash sector decoder.
`timescale 1ns / 1ps

package fasd_pkg;

    // Sectors taken into account, counted from the start of the first bank (12..24)
    localparam int SECTOR_COUNT = 24;

    localparam int BANK_SECTORS  = 12;
    localparam int ADDR_W        = 32;
    localparam int INDEX_W       = 5;
    localparam int LOCAL_W       = 4;
    localparam int LOCAL_OFS_W   = 20;
    localparam int ORIGIN_W      = 22;
    localparam int SIZE_W        = 18;
    localparam int SELECT_W      = 8;
    localparam int DEV_SIZE_W    = 16;
    localparam int KIB_SHIFT     = 10;
    localparam int LIMIT_W       = DEV_SIZE_W + KIB_SHIFT;

    localparam logic [SIZE_W-1:0] SIZE_SMALL  = SIZE_W'(16 * 1024);
    localparam logic [SIZE_W-1:0] SIZE_MEDIUM = SIZE_W'(64 * 1024);
    localparam logic [SIZE_W-1:0] SIZE_LARGE  = SIZE_W'(128 * 1024);

    // Erase sector-number bits: bank 2 flag and last selector of bank 1
    localparam logic [SELECT_W-1:0] BANK2_SELECT      = 8'h80;
    localparam logic [SELECT_W-1:0] BANK1_LAST_SELECT = 8'h58;

    localparam logic [DEV_SIZE_W-1:0] DEVICE_SIZE_RESET = 16'd1024;

    // Within-bank sector number of the 64 KiB sector
    localparam logic [LOCAL_W-1:0] LOCAL_MEDIUM      = 4'd4;

    // Register indexes on the configuration port
    localparam logic REG_DEVICE_SIZE = 1'b0;

    typedef struct packed {
        logic                  found;
        logic [INDEX_W-1:0]    sector_index;
        logic [ORIGIN_W-1:0]   sector_origin;
        logic [SIZE_W-1:0]     sector_size;
        logic [SELECT_W-1:0]   sector_select_bits;
    } t_result;

    // Offset of a sector from the start of its bank
    function automatic logic [LOCAL_OFS_W-1:0] local_origin(input logic [LOCAL_W-1:0] loc);
        logic [LOCAL_OFS_W-1:0] ofs;
        begin
            if (loc < LOCAL_MEDIUM) begin
                ofs = LOCAL_OFS_W'(loc) * LOCAL_OFS_W'(SIZE_SMALL);
            end else if (loc == LOCAL_MEDIUM) begin
                ofs = LOCAL_OFS_W'(SIZE_MEDIUM);
            end else begin
                ofs = LOCAL_OFS_W'(loc - LOCAL_MEDIUM) * LOCAL_OFS_W'(SIZE_LARGE);
            end
            return ofs;
        end
    endfunction

    function automatic logic [SIZE_W-1:0] local_size(input logic [LOCAL_W-1:0] loc);
        logic [SIZE_W-1:0] sz;
        begin
            if (loc < LOCAL_MEDIUM) begin
                sz = SIZE_SMALL;
            end else if (loc == LOCAL_MEDIUM) begin
                sz = SIZE_MEDIUM;
            end else begin
                sz = SIZE_LARGE;
            end
            return sz;
        end
    endfunction

endpackage

FILE: sv/flash_address_to_sector_decoder_unit.sv
// Top level: flash byte address to sector decoder with device size register.
`timescale 1ns / 1ps

// Maps a flash-relative byte address onto the dual-bank sector layout (per bank:
// four 16 KiB sectors, one 64 KiB sector, seven 128 KiB sectors; bank 2 follows
// bank 1 directly). Each result gives found, sector index, origin, size and the
// erase sector-number bits; on a miss every field is zero. A sector counts only
// if its origin lies below device_size_kib * 1024 (register at byte address 0,
// reset 1024) and its index is below SECTOR_COUNT. Throughput is one request per
// clock while i_ready does not stall the pipe; each request passes the three register
// stages of the decode pipe in order (bank/sector split, descriptor lookup, device
// size cut into the output register) before o_valid rises.
// A stall on i_ready freezes the whole pipe, so o_ready drops only while a finished
// result waits and i_ready is low.
// Write device_size_kib only while no request is in flight.

module flash_address_to_sector_decoder_unit
    import fasd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // Configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,

    // Request channel
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [ADDR_W-1:0]      i_address,

    // Result channel
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_found,
    output logic [INDEX_W-1:0]     o_sector_index,
    output logic [ORIGIN_W-1:0]    o_sector_origin,
    output logic [SIZE_W-1:0]      o_sector_size,
    output logic [SELECT_W-1:0]    o_sector_select_bits
);

    logic [DEV_SIZE_W-1:0] r_device_size_kib, n_device_size_kib;
    logic                  reg_index;
    logic                  cfg_write;
    t_result               result;

    // Word index: bit 2 of the byte address; low bits ignored
    assign reg_index = paddr[2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        n_device_size_kib = r_device_size_kib;
        if (cfg_write && reg_index == REG_DEVICE_SIZE) begin
            n_device_size_kib = pwdata[DEV_SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_size_kib <= DEVICE_SIZE_RESET;
        end else begin
            r_device_size_kib <= n_device_size_kib;
        end
    end

    // Read-back; unmapped word reads zero
    always_comb begin
        prdata = '0;
        if (reg_index == REG_DEVICE_SIZE) begin
            prdata = {{(32-DEV_SIZE_W){1'b0}}, r_device_size_kib};
        end
    end

    fasd_decode_pipe u_pipe (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_address         (i_address),
        .i_device_size_kib (r_device_size_kib),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_result          (result)
    );

    assign o_found              = result.found;
    assign o_sector_index       = result.sector_index;
    assign o_sector_origin      = result.sector_origin;
    assign o_sector_size        = result.sector_size;
    assign o_sector_select_bits = result.sector_select_bits;

endmodule

FILE: sv/fasd_decode_pipe.sv
// Module: three-stage decode pipeline from byte address to sector descriptor.
`timescale 1ns / 1ps

module fasd_decode_pipe
    import fasd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [ADDR_W-1:0]      i_address,
    input  logic [DEV_SIZE_W-1:0]  i_device_size_kib,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_result                o_result
);

    // Stage 1: split address into bank and within-bank sector
    logic                r_v1, n_v1;
    logic                r_bank1, n_bank1;
    logic [LOCAL_W-1:0]  r_local1, n_local1;
    logic                r_inrange1, n_inrange1;

    // Stage 2: sector number, origin, size, select bits
    logic                  r_v2;
    logic                  r_ok2, n_ok2;
    logic [INDEX_W-1:0]    r_idx2, n_idx2;
    logic [ORIGIN_W-1:0]   r_origin2, n_origin2;
    logic [SIZE_W-1:0]     r_size2, n_size2;
    logic [SELECT_W-1:0]   r_sel2, n_sel2;

    // Stage 3: device size cut, output register
    logic     r_v3;
    t_result  r_res3, n_res3;

    // Whole pipe advances together; a stall holds every stage
    logic advance;
    assign advance = !r_v3 || i_ready;
    assign o_ready = advance;

    always_comb begin
        n_v1       = i_valid;
        n_bank1    = i_address[LOCAL_OFS_W];
        n_inrange1 = (i_address[ADDR_W-1:LOCAL_OFS_W+1] == '0);
        if (i_address[LOCAL_OFS_W-1:17] != '0) begin
            n_local1 = LOCAL_W'(i_address[LOCAL_OFS_W-1:17]) + LOCAL_MEDIUM;
        end else if (i_address[16]) begin
            n_local1 = LOCAL_MEDIUM;
        end else begin
            n_local1 = LOCAL_W'(i_address[15:14]);
        end
    end

    always_comb begin
        n_idx2    = r_bank1 ? (INDEX_W'(r_local1) + INDEX_W'(BANK_SECTORS))
                            : INDEX_W'(r_local1);
        n_ok2     = r_inrange1 && (n_idx2 < INDEX_W'(SECTOR_COUNT));
        n_origin2 = {1'b0, r_bank1, local_origin(r_local1)};
        n_size2   = local_size(r_local1);
        n_sel2    = {r_bank1, r_local1, 3'b000};
    end

    always_comb begin
        n_res3 = '0;
        if (r_ok2 && ({{(LIMIT_W-ORIGIN_W){1'b0}}, r_origin2}
                      < {i_device_size_kib, {KIB_SHIFT{1'b0}}})) begin
            n_res3.found              = 1'b1;
            n_res3.sector_index       = r_idx2;
            n_res3.sector_origin      = r_origin2;
            n_res3.sector_size        = r_size2;
            n_res3.sector_select_bits = r_sel2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (advance) begin
            r_v1 <= n_v1;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_bank1    <= n_bank1;
            r_local1   <= n_local1;
            r_inrange1 <= n_inrange1;
            r_ok2      <= n_ok2;
            r_idx2     <= n_idx2;
            r_origin2  <= n_origin2;
            r_size2    <= n_size2;
            r_sel2     <= n_sel2;
            r_res3     <= n_res3;
        end
    end

    assign o_valid  = r_v3;
    assign o_result = r_res3;

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !r_res3.found) |-> (r_res3.sector_index == '0 && r_res3.sector_origin == '0
            && r_res3.sector_size == '0 && r_res3.sector_select_bits == '0))
        else $error("miss carries non-zero fields");

    a_size_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_res3.found) |-> (r_res3.sector_size == SIZE_SMALL
            || r_res3.sector_size == SIZE_MEDIUM || r_res3.sector_size == SIZE_LARGE))
        else $error("illegal sector size");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_res3.found) |-> (r_res3.sector_index < INDEX_W'(SECTOR_COUNT)))
        else $error("sector index beyond count");

    a_select_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_res3.found) |-> ((r_res3.sector_select_bits[SELECT_W-1]
            == (r_res3.sector_index >= INDEX_W'(BANK_SECTORS)))
            && (r_res3.sector_select_bits[SELECT_W-1]
                || r_res3.sector_select_bits <= BANK1_LAST_SELECT)))
        else $error("select bits disagree with bank");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_v3 && !i_ready) |=> (r_v2 && $stable(r_idx2)))
        else $error("stage 2 lost during stall");

endmodule
